>>> design/adhm_pkg.sv
// adhm_pkg: shared widths, constants, status codes and the angle range check
// for the angle/distance/height meter. No dependencies.
`default_nettype none
package adhm_pkg;

  localparam int ANGLE_W = 32;   // Q1.31 radians
  localparam int CAM_W   = 23;   // Q7.16
  localparam int OUT_W   = 48;   // Q32.16

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 32'd3006477107;  // floor(1.4 * 2^31)
  localparam logic [OUT_W-1:0]   OUT_MAX   = '1;
  localparam logic [CAM_W-1:0]   CAM_RESET = 23'd98304;       // 1.5

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_BAD_A = 2'd1,
    STATUS_BAD_B = 2'd2
  } status_t;

  function automatic logic angle_ok(input logic [ANGLE_W-1:0] ang);
    return (ang != '0) && (ang <= ANGLE_MAX);
  endfunction

endpackage
`default_nettype wire

>>> design/adhm_in_if.sv
// adhm_in_if: valid/ready channel carrying angle a, an optional angle b and its has_b flag.
// Depends on adhm_pkg for field widths.
`default_nettype none
interface adhm_in_if;
  logic                        valid;
  logic                        ready;
  logic [adhm_pkg::ANGLE_W-1:0] angle_a;
  logic [adhm_pkg::ANGLE_W-1:0] angle_b;
  logic                        has_b;

  modport source (output valid, angle_a, angle_b, has_b, input ready);
  modport sink   (input valid, angle_a, angle_b, has_b, output ready);
endinterface
`default_nettype wire

>>> design/adhm_out_if.sv
// adhm_out_if: valid/ready channel carrying one result word.
// Depends on adhm_pkg for field widths and the status type.
`default_nettype none
interface adhm_out_if;
  logic                       valid;
  logic                       ready;
  logic [adhm_pkg::OUT_W-1:0] distance;
  logic [adhm_pkg::OUT_W-1:0] object_height;
  logic                       height_valid;
  adhm_pkg::status_t          status;

  modport source (output valid, distance, object_height, height_valid, status, input ready);
  modport sink   (input valid, distance, object_height, height_valid, status, output ready);
endinterface
`default_nettype wire

>>> design/adhm_div.sv
// adhm_div: pipelined restoring divider, one quotient bit per stage, with a
// sideband word and valid bit carried alongside. Quotient rounding is done by
// the caller through the dividend. Requires num < den << QW. No dependencies.
`default_nettype none
module adhm_div #(
  parameter int NW = 63,
  parameter int DW = 35,
  parameter int QW = 30,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  localparam int W = DW + QW;

  logic          vld_r  [QW];
  logic [W-1:0]  rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [SW-1:0] side_r [QW];

  logic          vld_src  [QW];
  logic [W-1:0]  rem_src  [QW];
  logic [DW-1:0] den_src  [QW];
  logic [QW-1:0] quo_src  [QW];
  logic [SW-1:0] side_src [QW];
  logic [W:0]    trial    [QW];
  logic [W-1:0]  rem_nxt  [QW];
  logic [QW-1:0] quo_nxt  [QW];

  always_comb begin
    vld_src[0]  = in_vld;
    rem_src[0]  = W'(in_num);
    den_src[0]  = in_den;
    quo_src[0]  = '0;
    side_src[0] = in_side;
    for (int s = 1; s < QW; s++) begin
      vld_src[s]  = vld_r[s-1];
      rem_src[s]  = rem_r[s-1];
      den_src[s]  = den_r[s-1];
      quo_src[s]  = quo_r[s-1];
      side_src[s] = side_r[s-1];
    end
    // stage s decides quotient bit QW-1-s
    for (int s = 0; s < QW; s++) begin
      trial[s] = {1'b0, rem_src[s]} - {1'b0, W'(den_src[s]) << (QW - 1 - s)};
      if (!trial[s][W]) begin
        rem_nxt[s] = trial[s][W-1:0];
        quo_nxt[s] = quo_src[s] | (QW'(1) << (QW - 1 - s));
      end else begin
        rem_nxt[s] = rem_src[s];
        quo_nxt[s] = quo_src[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < QW; s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      for (int s = 0; s < QW; s++) vld_r[s] <= vld_src[s];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < QW; s++) begin
        rem_r[s]  <= rem_nxt[s];
        den_r[s]  <= den_src[s];
        quo_r[s]  <= quo_nxt[s];
        side_r[s] <= side_src[s];
      end
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign out_quo  = quo_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule
`default_nettype wire

>>> design/angle_distance_height_meter.sv
// angle_distance_height_meter: top level. Uses adhm_pkg, adhm_in_if,
// adhm_out_if and the pipelined divider adhm_div.
//
// Accepts one angle word per clock while the output is not stalled and returns
// one result word per input, in order. The pipeline is one squaring stage, 30
// bit-serial divider stages for each of the CF_TERMS-1 continued-fraction
// terms, 34 for the tangent quotient, 55 for the distance quotient, and three
// stages for the height product, rounding and output register. The whole
// pipeline holds when the output word is not taken, so in_ch.ready is low only
// while a finished word waits. Write camera_height through cfg_we/cfg_wdata
// only while the pipeline is empty.
`default_nettype none
module angle_distance_height_meter #(
  parameter int CF_TERMS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  adhm_in_if.sink                     in_ch,
  adhm_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [adhm_pkg::CAM_W-1:0]  cfg_wdata
);

  localparam int AW    = adhm_pkg::ANGLE_W;
  localparam int OW    = adhm_pkg::OUT_W;
  localparam int CW    = adhm_pkg::CAM_W;
  localparam int CF_N  = CF_TERMS - 1;
  localparam int CF_QW = 30;
  localparam int CF_DW = $clog2(2 * CF_TERMS) + CF_QW;
  localparam int CF_NW = AW + CF_QW + 1;
  localparam int TN_QW = 34;
  localparam int TN_DW = CF_QW + 1;
  localparam int TN_NW = AW + CF_QW + 1;
  localparam int DS_QW = CW + 32;
  localparam int DS_DW = TN_QW;
  localparam int DS_NW = CW + 32;
  localparam int PW    = TN_QW + OW;

  typedef struct packed {
    logic [AW-1:0]     ang;
    logic [AW-1:0]     x2;
    adhm_pkg::status_t status;
  } cf_side_a_t;

  typedef struct packed {
    logic [AW-1:0] ang;
    logic [AW-1:0] x2;
    logic          has_b;
  } cf_side_b_t;

  typedef struct packed {
    logic [TN_QW-1:0]  tan_b;
    adhm_pkg::status_t status;
    logic              has_b;
  } ds_side_t;

  logic [CW-1:0] cam_r;
  logic          en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r <= adhm_pkg::CAM_RESET;
    end else if (cfg_we) begin
      cam_r <= cfg_wdata;
    end
  end

  logic out_vld_r;
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- squaring stage ----------------
  adhm_pkg::status_t in_status;
  logic [63:0]       sq_a, sq_b;
  logic              m_vld_r;
  cf_side_a_t        m_a_r;
  cf_side_b_t        m_b_r;

  always_comb begin
    if (!adhm_pkg::angle_ok(in_ch.angle_a)) begin
      in_status = adhm_pkg::STATUS_BAD_A;
    end else if (in_ch.has_b && !adhm_pkg::angle_ok(in_ch.angle_b)) begin
      in_status = adhm_pkg::STATUS_BAD_B;
    end else begin
      in_status = adhm_pkg::STATUS_OK;
    end
    sq_a = 64'(in_ch.angle_a) * 64'(in_ch.angle_a) + 64'h8000_0000;
    sq_b = 64'(in_ch.angle_b) * 64'(in_ch.angle_b) + 64'h8000_0000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_a_r.ang    <= in_ch.angle_a;
      m_a_r.x2     <= sq_a[63:32];
      m_a_r.status <= in_status;
      m_b_r.ang    <= in_ch.angle_b;
      m_b_r.x2     <= sq_b[63:32];
      m_b_r.has_b  <= in_ch.has_b;
    end
  end

  // ---------------- continued fraction, innermost term first ----------------
  logic             cf_vld_a [CF_TERMS];
  logic             cf_vld_b [CF_TERMS];
  logic [CF_QW-1:0] cf_a     [CF_TERMS];
  logic [CF_QW-1:0] cf_b     [CF_TERMS];
  cf_side_a_t       cf_sa    [CF_TERMS];
  cf_side_b_t       cf_sb    [CF_TERMS];

  assign cf_vld_a[0] = m_vld_r;
  assign cf_vld_b[0] = m_vld_r;
  assign cf_a[0]     = '0;
  assign cf_b[0]     = '0;
  assign cf_sa[0]    = m_a_r;
  assign cf_sb[0]    = m_b_r;

  for (genvar i = 0; i < CF_N; i++) begin : g_cf
    localparam logic [CF_DW-1:0] ODD = CF_DW'(2 * (CF_TERMS - i) - 1) << CF_QW;
    logic [CF_DW-1:0] den_a, den_b;
    logic [CF_NW-1:0] num_a, num_b;

    assign den_a = ODD - CF_DW'(cf_a[i]);
    assign den_b = ODD - CF_DW'(cf_b[i]);
    assign num_a = (CF_NW'(cf_sa[i].x2) << CF_QW) + CF_NW'(den_a >> 1);
    assign num_b = (CF_NW'(cf_sb[i].x2) << CF_QW) + CF_NW'(den_b >> 1);

    adhm_div #(.NW(CF_NW), .DW(CF_DW), .QW(CF_QW), .SW($bits(cf_side_a_t))) u_div_a (
      .clk, .rst_n, .en,
      .in_vld  (cf_vld_a[i]),   .in_num (num_a), .in_den (den_a), .in_side (cf_sa[i]),
      .out_vld (cf_vld_a[i+1]), .out_quo(cf_a[i+1]),            .out_side(cf_sa[i+1])
    );

    adhm_div #(.NW(CF_NW), .DW(CF_DW), .QW(CF_QW), .SW($bits(cf_side_b_t))) u_div_b (
      .clk, .rst_n, .en,
      .in_vld  (cf_vld_b[i]),   .in_num (num_b), .in_den (den_b), .in_side (cf_sb[i]),
      .out_vld (cf_vld_b[i+1]), .out_quo(cf_b[i+1]),            .out_side(cf_sb[i+1])
    );
  end

  // ---------------- tan = x / (1 - cf) ----------------
  logic [TN_DW-1:0] tn_den_a, tn_den_b;
  logic [TN_NW-1:0] tn_num_a, tn_num_b;
  logic             tn_vld_a, tn_vld_b;
  logic [TN_QW-1:0] tan_a, tan_b;
  logic [1:0]       tn_status;
  logic             tn_has_b;

  assign tn_den_a = (TN_DW'(1) << CF_QW) - TN_DW'(cf_a[CF_N]);
  assign tn_den_b = (TN_DW'(1) << CF_QW) - TN_DW'(cf_b[CF_N]);
  assign tn_num_a = (TN_NW'(cf_sa[CF_N].ang) << CF_QW) + TN_NW'(tn_den_a >> 1);
  assign tn_num_b = (TN_NW'(cf_sb[CF_N].ang) << CF_QW) + TN_NW'(tn_den_b >> 1);

  adhm_div #(.NW(TN_NW), .DW(TN_DW), .QW(TN_QW), .SW(2)) u_tan_a (
    .clk, .rst_n, .en,
    .in_vld  (cf_vld_a[CF_N]), .in_num (tn_num_a), .in_den(tn_den_a),
    .in_side (cf_sa[CF_N].status),
    .out_vld (tn_vld_a),       .out_quo(tan_a),    .out_side(tn_status)
  );

  adhm_div #(.NW(TN_NW), .DW(TN_DW), .QW(TN_QW), .SW(1)) u_tan_b (
    .clk, .rst_n, .en,
    .in_vld  (cf_vld_b[CF_N]), .in_num (tn_num_b), .in_den(tn_den_b),
    .in_side (cf_sb[CF_N].has_b),
    .out_vld (tn_vld_b),       .out_quo(tan_b),    .out_side(tn_has_b)
  );

  // ---------------- distance = cam / tan_a ----------------
  logic [DS_NW-1:0] ds_num;
  ds_side_t         ds_in_side, ds_side;
  logic             ds_vld;
  logic [DS_QW-1:0] ds_quo;

  assign ds_num           = (DS_NW'(cam_r) << 31) + DS_NW'(tan_a >> 1);
  assign ds_in_side.tan_b = tan_b;
  assign ds_in_side.status = adhm_pkg::status_t'(tn_status);
  assign ds_in_side.has_b = tn_has_b;

  adhm_div #(.NW(DS_NW), .DW(DS_DW), .QW(DS_QW), .SW($bits(ds_side_t))) u_dist (
    .clk, .rst_n, .en,
    .in_vld  (tn_vld_a), .in_num (ds_num), .in_den(tan_a), .in_side (ds_in_side),
    .out_vld (ds_vld),   .out_quo(ds_quo),                 .out_side(ds_side)
  );

  // ---------------- height: partial products ----------------
  logic [OW-1:0]     d_sat;
  logic              h1_vld_r;
  logic [OW-1:0]     h1_d_r;
  logic [63:0]       h1_pp0_r;
  logic [47:0]       h1_pp1_r;
  logic [OW+1:0]     h1_pp2_r;
  adhm_pkg::status_t h1_status_r;
  logic              h1_has_b_r;

  assign d_sat = (ds_quo > DS_QW'(adhm_pkg::OUT_MAX)) ? adhm_pkg::OUT_MAX : ds_quo[OW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_vld_r <= 1'b0;
    end else if (en) begin
      h1_vld_r <= ds_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1_d_r      <= d_sat;
      h1_pp0_r    <= 64'(ds_side.tan_b[31:0]) * 64'(d_sat[31:0]);
      h1_pp1_r    <= 48'(ds_side.tan_b[31:0]) * 48'(d_sat[47:32]);
      h1_pp2_r    <= (OW+2)'(ds_side.tan_b[33:32]) * (OW+2)'(d_sat);
      h1_status_r <= ds_side.status;
      h1_has_b_r  <= ds_side.has_b;
    end
  end

  // ---------------- height: sum and round to Q.16 ----------------
  logic [PW-1:0]     h2_prod;
  logic              h2_vld_r;
  logic [OW-1:0]     h2_d_r;
  logic [PW-32:0]    h2_hq_r;
  adhm_pkg::status_t h2_status_r;
  logic              h2_has_b_r;

  assign h2_prod = PW'(h1_pp0_r) + (PW'(h1_pp1_r) << 32) + (PW'(h1_pp2_r) << 32)
                 + (PW'(1) << 30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h2_vld_r <= 1'b0;
    end else if (en) begin
      h2_vld_r <= h1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h2_d_r      <= h1_d_r;
      h2_hq_r     <= h2_prod[PW-1:31];
      h2_status_r <= h1_status_r;
      h2_has_b_r  <= h1_has_b_r;
    end
  end

  // ---------------- add camera height, saturate, output register ----------------
  logic [PW-31:0]    h_sum;
  logic [OW-1:0]     h_sat;
  logic              ok;
  logic [OW-1:0]     out_dist_r;
  logic [OW-1:0]     out_hgt_r;
  logic              out_hv_r;
  adhm_pkg::status_t out_status_r;

  assign h_sum = (PW-30)'(h2_hq_r) + (PW-30)'(cam_r);
  assign h_sat = (h_sum > (PW-30)'(adhm_pkg::OUT_MAX)) ? adhm_pkg::OUT_MAX : h_sum[OW-1:0];
  assign ok    = (h2_status_r == adhm_pkg::STATUS_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= h2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_dist_r   <= ok ? h2_d_r : '0;
      out_hgt_r    <= (ok && h2_has_b_r) ? h_sat : '0;
      out_hv_r     <= ok && h2_has_b_r;
      out_status_r <= h2_status_r;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.distance      = out_dist_r;
  assign out_ch.object_height = out_hgt_r;
  assign out_ch.height_valid  = out_hv_r;
  assign out_ch.status        = out_status_r;

  // ---------------- assertions ----------------
  a_tan_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    tn_vld_a == tn_vld_b)
    else $error("tangent chains for angle a and angle b out of step");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_status_r != adhm_pkg::STATUS_OK)
      |-> (out_dist_r == '0) && (out_hgt_r == '0) && !out_hv_r)
    else $error("error word carries nonzero result fields");

  a_hv_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_hv_r |-> out_status_r == adhm_pkg::STATUS_OK)
    else $error("height flagged valid on an error word");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(out_dist_r))
    else $error("pending output word dropped or changed during stall");

endmodule
`default_nettype wire
